[rtl/core/mlg_pkg.sv]
// Shared types, constants and floating-point helper functions for the MAPE loss block.
package mlg_pkg;

  localparam logic [31:0] LABEL_EPS  = 32'h38D1B717;  // 0.0001
  localparam logic [31:0] MAX_MAG    = 32'h447A0000;  // 1000.0
  localparam logic [31:0] PERCENT    = 32'h42C80000;  // 100.0
  localparam logic [31:0] QNAN       = 32'hFFC00000;
  localparam logic [31:0] QUIET_BIT  = 32'h00400000;

  localparam int ADD_LAT  = 3;
  localparam int MUL_LAT  = 3;
  localparam int DIV_NQ   = 26;
  localparam int DIV_IPS  = 4;
  localparam int DIV_NST  = (DIV_NQ + DIV_IPS - 1) / DIV_IPS;
  localparam int DIV_LAT  = DIV_NST + 2;

  typedef enum logic [1:0] {
    REG_LOSS_HALF  = 2'd0,
    REG_GRAD_HALF  = 2'd1,
    REG_LOSS_SCALE = 2'd2
  } cfg_reg_e;

  typedef logic signed [9:0] exp_t;
  typedef logic [26:0] mant_t;

  typedef struct packed {
    logic       sign;
    logic       nan;
    logic       inf;
    logic       zero;
    exp_t       exp;
    logic [23:0] mant;
  } unp_t;

  typedef struct packed {
    logic nan;
    logic inf;
    logic zero;
  } spec_t;

  typedef struct packed {
    logic zm;
    logic pos;
    logic neg;
  } side_t;

  // Unpacks a single, normalising subnormals so that mant[23] is set.
  function automatic unp_t fp_unpack(input logic [31:0] b);
    unp_t u;
    logic [4:0] k;
    k = 5'd0;
    for (int i = 0; i < 23; i++) begin
      if (b[i]) k = 5'(i);
    end
    u.sign = b[31];
    u.nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    u.inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    u.zero = (b[30:0] == 31'd0);
    if (b[30:23] != 8'd0) begin
      u.exp  = $signed({2'b00, b[30:23]}) - 10'sd127;
      u.mant = {1'b1, b[22:0]};
    end else begin
      u.exp  = $signed({5'b00000, k}) - 10'sd149;
      u.mant = {1'b0, b[22:0]} << (5'd23 - k);
    end
    return u;
  endfunction

  // Rounds m/2^26 * 2^ex to nearest even; m[26] must be set unless the result is tiny.
  function automatic logic [31:0] fp_round(input logic sign, input exp_t ex, input mant_t m);
    logic signed [10:0] be;
    logic [4:0]  sh;
    mant_t       ms;
    logic        st;
    logic        g;
    logic        rest;
    logic        lsb;
    logic [30:0] pk;
    be = $signed({ex[9], ex}) + 11'sd127;
    if (be >= 11'sd255) begin
      return {sign, 8'hFF, 23'd0};
    end
    if (be >= 11'sd1) begin
      pk   = {be[7:0], m[25:3]};
      lsb  = m[3];
      g    = m[2];
      rest = m[1] | m[0];
    end else begin
      if (be < -11'sd25) sh = 5'd27;
      else               sh = 5'(11'sd1 - be);
      ms   = m >> sh;
      st   = |(m & ~({27{1'b1}} << sh));
      pk   = {8'h00, ms[25:3]};
      lsb  = ms[3];
      g    = ms[2];
      rest = ms[1] | ms[0] | st;
    end
    return {sign, pk + 31'(g && (rest || lsb))};
  endfunction

  // Single to half conversion, round to nearest even.
  function automatic logic [15:0] to_half(input logic [31:0] b);
    logic        s;
    logic [7:0]  ex;
    logic [22:0] man;
    logic [23:0] m;
    logic [23:0] rem;
    logic [23:0] hw;
    logic [4:0]  sh;
    logic [15:0] h;
    logic [12:0] r13;
    s   = b[31];
    ex  = b[30:23];
    man = b[22:0];
    if (ex == 8'hFF) begin
      return {s, 5'h1F, man != 23'd0, 9'd0};
    end
    if (ex >= 8'd143) begin
      return {s, 15'h7C00};
    end
    if (ex <= 8'd112) begin
      if (ex < 8'd102) begin
        return {s, 15'd0};
      end
      m   = {1'b1, man};
      sh  = 5'(8'd126 - ex);
      rem = m & ~({24{1'b1}} << sh);
      hw  = 24'd1 << (sh - 5'd1);
      h   = 16'(m >> sh);
      if ((rem > hw) || ((rem == hw) && h[0])) h = h + 16'd1;
      return {s, h[14:0]};
    end
    h   = {1'b0, 5'(ex - 8'd112), man[22:13]};
    r13 = man[12:0];
    if ((r13 > 13'h1000) || ((r13 == 13'h1000) && h[0])) h = h + 16'd1;
    return {s, h[14:0]};
  endfunction

  // Maps a single to an unsigned key that orders like the numbers themselves.
  function automatic logic [31:0] fp_key(input logic [31:0] b);
    return b[31] ? ~b : {1'b1, b[30:0]};
  endfunction

endpackage

[rtl/core/mlg_if.sv]
// Valid/ready channel interfaces for the input and result beats.
interface mlg_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] prediction;
  logic [31:0] label;
  modport source (output valid, output prediction, output label, input ready);
  modport sink   (input valid, input prediction, input label, output ready);
endinterface

interface mlg_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] loss_value;
  logic [31:0] grad_value;
  modport source (output valid, output loss_value, output grad_value, input ready);
  modport sink   (input valid, input loss_value, input grad_value, output ready);
endinterface

[rtl/core/mlg_fadd.sv]
// Three-stage single-precision subtractor: align, add and normalise, round.
module mlg_fadd import mlg_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] dif_o
);

  logic        s1_sign_q, s1_sub_q, s1_nan_q, s1_inf_q;
  logic [7:0]  s1_exp_q;
  mant_t       s1_ml_q, s1_ms_q;
  logic        s1_sign_d, s1_sub_d, s1_nan_d, s1_inf_d;
  logic [7:0]  s1_exp_d;
  mant_t       s1_ml_d, s1_ms_d;

  logic        s2_sign_q, s2_nan_q, s2_inf_q, s2_zero_q;
  exp_t        s2_exp_q;
  mant_t       s2_m_q;
  logic        s2_zero_d;
  exp_t        s2_exp_d;
  mant_t       s2_m_d;

  logic [31:0] dif_q, dif_d;

  always_comb begin
    logic [31:0] nb, lg, sm;
    logic [7:0]  es;
    logic [7:0]  d;
    logic [4:0]  sh;
    mant_t       ms;
    logic        a_nan, b_nan;
    nb     = {~b_i[31], b_i[30:0]};
    lg     = (nb[30:0] > a_i[30:0]) ? nb : a_i;
    sm     = (nb[30:0] > a_i[30:0]) ? a_i : nb;
    s1_exp_d = (lg[30:23] == 8'd0) ? 8'd1 : lg[30:23];
    es     = (sm[30:23] == 8'd0) ? 8'd1 : sm[30:23];
    d      = s1_exp_d - es;
    sh     = (d > 8'd27) ? 5'd27 : d[4:0];
    s1_ml_d = {lg[30:23] != 8'd0, lg[22:0], 3'b000};
    ms     = {sm[30:23] != 8'd0, sm[22:0], 3'b000};
    s1_ms_d = (ms >> sh) | mant_t'(|(ms & ~({27{1'b1}} << sh)));
    s1_sign_d = lg[31];
    s1_sub_d  = lg[31] ^ sm[31];
    a_nan  = (a_i[30:23] == 8'hFF) && (a_i[22:0] != 23'd0);
    b_nan  = (b_i[30:23] == 8'hFF) && (b_i[22:0] != 23'd0);
    s1_inf_d = (lg[30:0] == 31'h7F800000);
    s1_nan_d = a_nan || b_nan || (s1_inf_d && (sm[30:0] == 31'h7F800000) && s1_sub_d);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_sign_q <= s1_sign_d;
      s1_sub_q  <= s1_sub_d;
      s1_nan_q  <= s1_nan_d;
      s1_inf_q  <= s1_inf_d;
      s1_exp_q  <= s1_exp_d;
      s1_ml_q   <= s1_ml_d;
      s1_ms_q   <= s1_ms_d;
    end
  end

  always_comb begin
    logic [27:0] sum;
    logic [27:0] shl;
    logic [4:0]  lz;
    exp_t        ex0;
    sum = s1_sub_q ? ({1'b0, s1_ml_q} - {1'b0, s1_ms_q}) : ({1'b0, s1_ml_q} + {1'b0, s1_ms_q});
    lz  = 5'd0;
    for (int i = 0; i < 28; i++) begin
      if (sum[i]) lz = 5'(27 - i);
    end
    ex0 = $signed({2'b00, s1_exp_q}) - 10'sd127;
    shl = sum << (lz - 5'd1);
    if (lz == 5'd0) begin
      s2_m_d   = {sum[27:2], sum[1] | sum[0]};
      s2_exp_d = ex0 + 10'sd1;
    end else begin
      s2_m_d   = shl[26:0];
      s2_exp_d = ex0 - $signed({5'b00000, lz}) + 10'sd1;
    end
    s2_zero_d = (sum == 28'd0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_sign_q <= s1_sign_q;
      s2_nan_q  <= s1_nan_q;
      s2_inf_q  <= s1_inf_q;
      s2_zero_q <= s2_zero_d;
      s2_exp_q  <= s2_exp_d;
      s2_m_q    <= s2_m_d;
    end
  end

  always_comb begin
    if (s2_nan_q)       dif_d = QNAN;
    else if (s2_inf_q)  dif_d = {s2_sign_q, 8'hFF, 23'd0};
    else if (s2_zero_q) dif_d = 32'd0;
    else                dif_d = fp_round(s2_sign_q, s2_exp_q, s2_m_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) dif_q <= dif_d;
  end

  assign dif_o = dif_q;

endmodule

[rtl/core/mlg_fdiv.sv]
// Pipelined magnitude divider |a|/|b|: unpack, restoring iterations, round.
module mlg_fdiv import mlg_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] quo_o
);

  logic [24:0]         rem_q [DIV_NST+1];
  logic [DIV_NQ-1:0]   quo_q [DIV_NST+1];
  logic [23:0]         dvs_q [DIV_NST+1];
  exp_t                exp_q [DIV_NST+1];
  spec_t               spc_q [DIV_NST+1];
  logic [31:0]         res_q, res_d;

  always_ff @(posedge clk_i) begin
    unp_t  ua, ub;
    logic  lt;
    if (en_i) begin
      ua = fp_unpack(a_i);
      ub = fp_unpack(b_i);
      lt = ua.mant < ub.mant;
      rem_q[0]      <= lt ? {ua.mant, 1'b0} : {1'b0, ua.mant};
      quo_q[0]      <= '0;
      dvs_q[0]      <= ub.mant;
      exp_q[0]      <= ua.exp - ub.exp - exp_t'(lt);
      spc_q[0].nan  <= ua.nan || ub.nan || (ua.inf && ub.inf) || (ua.zero && ub.zero);
      spc_q[0].inf  <= ua.inf || ub.zero;
      spc_q[0].zero <= ua.zero || ub.inf;
    end
  end

  for (genvar s = 0; s < DIV_NST; s++) begin : g_iter
    logic [24:0]       r_d;
    logic [DIV_NQ-1:0] q_d;

    always_comb begin
      r_d = rem_q[s];
      q_d = quo_q[s];
      for (int k = 0; k < DIV_IPS; k++) begin
        if (s * DIV_IPS + k < DIV_NQ) begin
          if (r_d >= {1'b0, dvs_q[s]}) begin
            q_d = {q_d[DIV_NQ-2:0], 1'b1};
            r_d = r_d - {1'b0, dvs_q[s]};
          end else begin
            q_d = {q_d[DIV_NQ-2:0], 1'b0};
          end
          r_d = r_d << 1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= r_d;
        quo_q[s+1] <= q_d;
        dvs_q[s+1] <= dvs_q[s];
        exp_q[s+1] <= exp_q[s];
        spc_q[s+1] <= spc_q[s];
      end
    end
  end

  always_comb begin
    if (spc_q[DIV_NST].nan)       res_d = QNAN;
    else if (spc_q[DIV_NST].inf)  res_d = 32'h7F800000;
    else if (spc_q[DIV_NST].zero) res_d = 32'd0;
    else res_d = fp_round(1'b0, exp_q[DIV_NST],
                          {quo_q[DIV_NST], rem_q[DIV_NST] != 25'd0});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) res_q <= res_d;
  end

  assign quo_o = res_q;

endmodule

[rtl/core/mlg_fmul.sv]
// Three-stage single-precision multiplier: unpack, multiply, normalise and round.
module mlg_fmul import mlg_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] prod_o
);

  logic [23:0] s1_ma_q, s1_mb_q;
  exp_t        s1_exp_q, s2_exp_q;
  logic        s1_sign_q, s2_sign_q;
  spec_t       s1_spc_q, s2_spc_q;
  logic [31:0] s1_nanv_q, s2_nanv_q;
  logic [47:0] s2_prod_q;
  logic [31:0] res_q, res_d;

  always_ff @(posedge clk_i) begin
    unp_t ua, ub;
    if (en_i) begin
      ua = fp_unpack(a_i);
      ub = fp_unpack(b_i);
      s1_ma_q       <= ua.mant;
      s1_mb_q       <= ub.mant;
      s1_exp_q      <= ua.exp + ub.exp;
      s1_sign_q     <= ua.sign ^ ub.sign;
      s1_spc_q.nan  <= ua.nan || ub.nan || (ua.zero && ub.inf) || (ua.inf && ub.zero);
      s1_spc_q.inf  <= ua.inf || ub.inf;
      s1_spc_q.zero <= ua.zero || ub.zero;
      // A signalling operand comes back quietened; an invalid product gives the default NaN.
      s1_nanv_q     <= ua.nan ? (a_i | QUIET_BIT) : (ub.nan ? (b_i | QUIET_BIT) : QNAN);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_prod_q <= s1_ma_q * s1_mb_q;
      s2_exp_q  <= s1_exp_q;
      s2_sign_q <= s1_sign_q;
      s2_spc_q  <= s1_spc_q;
      s2_nanv_q <= s1_nanv_q;
    end
  end

  always_comb begin
    mant_t m;
    exp_t  ex;
    if (s2_prod_q[47]) begin
      m  = {s2_prod_q[47:22], s2_prod_q[21] | (|s2_prod_q[20:0])};
      ex = s2_exp_q + 10'sd1;
    end else begin
      m  = {s2_prod_q[46:21], s2_prod_q[20] | (|s2_prod_q[19:0])};
      ex = s2_exp_q;
    end
    if (s2_spc_q.nan)       res_d = s2_nanv_q;
    else if (s2_spc_q.inf)  res_d = {s2_sign_q, 8'hFF, 23'd0};
    else if (s2_spc_q.zero) res_d = {s2_sign_q, 31'd0};
    else                    res_d = fp_round(s2_sign_q, ex, m);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) res_q <= res_d;
  end

  assign prod_o = res_q;

endmodule

[rtl/core/mape_loss_gradient.sv]
// MAPE loss and scaled gradient, a streaming pipeline over single-precision element pairs.
//
// Usage: each input beat on in_i carries a prediction and a label as FP32 bit patterns;
// each result beat on out_o carries the loss and the scaled gradient, each as FP32 bits
// or, when the matching half flag is set, as FP16 bits in the low half.
// The configuration port writes loss_half, grad_half and loss_scale; write it only while
// no beat is in flight.
// One beat is accepted every cycle unless the receiver stalls. The path runs through the
// subtractor (3 stages), the two parallel 26-bit restoring dividers (9 stages, four
// quotient bits per stage) and the multipliers (3 stages), plus the input, label and
// output registers.
// When the receiver stalls with a result waiting, the whole pipeline holds and in_i.ready
// drops; nothing is lost or repeated. Bubbles travel as cleared valid bits.
// Reset clears every valid bit and loads the registers with FP32 output and a scale of 1.0;
// no clearing pass is needed.
module mape_loss_gradient import mlg_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  mlg_in_if.sink        in_i,
  mlg_out_if.source     out_o,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [31:0]   cfg_wdata_i
);

  localparam int Lat  = 2 + ADD_LAT + DIV_LAT + MUL_LAT + 1;
  localparam int SdN  = ADD_LAT + DIV_LAT;

  logic          loss_half_q, grad_half_q;
  logic [31:0]   loss_scale_q;
  logic [Lat-1:0] v_q;
  logic          en;

  logic [31:0]   p0_q, l0_q;
  logic [31:0]   p1_q, le1_q, le_d;
  side_t         side1_q, side1_d;
  logic [31:0]   le_dq [ADD_LAT];
  side_t         sd_q [SdN];
  logic          zm_dq [MUL_LAT];

  logic [31:0]   ediff, ratio, q_grad, grad_pre, pct, grad_sc;
  logic [31:0]   loss32, out_loss_q, out_grad_q, out_loss_d, out_grad_d;
  logic          out_zm_q;

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loss_half_q  <= 1'b0;
      grad_half_q  <= 1'b0;
      loss_scale_q <= 32'h3F800000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LOSS_HALF:  loss_half_q  <= cfg_wdata_i[0];
        REG_GRAD_HALF:  grad_half_q  <= cfg_wdata_i[0];
        REG_LOSS_SCALE: loss_scale_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign en         = !v_q[Lat-1] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[Lat-2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p0_q <= in_i.prediction;
      l0_q <= in_i.label;
    end
  end

  // Push the label away from zero, and work out the exact-match and sign flags.
  always_comb begin
    logic l_nan, p_nan;
    l_nan = (l0_q[30:23] == 8'hFF) && (l0_q[22:0] != 23'd0);
    p_nan = (p0_q[30:23] == 8'hFF) && (p0_q[22:0] != 23'd0);
    if (l_nan) begin
      le_d = LABEL_EPS;
    end else if (l0_q[31] && (l0_q[30:0] != 31'd0)) begin
      le_d = (l0_q[30:0] < LABEL_EPS[30:0]) ? {1'b1, LABEL_EPS[30:0]} : l0_q;
    end else begin
      le_d = (l0_q[30:0] > LABEL_EPS[30:0]) ? l0_q : LABEL_EPS;
    end
    side1_d.zm  = ((p0_q == l0_q) && (p0_q[30:23] != 8'hFF)) ||
                  ((p0_q[30:0] == 31'd0) && (l0_q[30:0] == 31'd0));
    side1_d.pos = !p_nan && (fp_key(p0_q) > fp_key(le_d));
    side1_d.neg = !p_nan && (fp_key(p0_q) < fp_key(le_d));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q    <= p0_q;
      le1_q   <= le_d;
      side1_q <= side1_d;
    end
  end

  mlg_fadd u_sub (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (p1_q),
    .b_i   (le1_q),
    .dif_o (ediff)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      le_dq[0] <= le1_q;
      for (int i = 1; i < ADD_LAT; i++) le_dq[i] <= le_dq[i-1];
      sd_q[0] <= side1_q;
      for (int i = 1; i < SdN; i++) sd_q[i] <= sd_q[i-1];
    end
  end

  mlg_fdiv u_div_loss (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (ediff),
    .b_i   (le_dq[ADD_LAT-1]),
    .quo_o (ratio)
  );

  mlg_fdiv u_div_grad (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (PERCENT),
    .b_i   (le_dq[ADD_LAT-1]),
    .quo_o (q_grad)
  );

  // Signed gradient clamped to the magnitude limit; zero on exact match or no sign flag set.
  always_comb begin
    if (sd_q[SdN-1].zm || !(sd_q[SdN-1].pos || sd_q[SdN-1].neg)) begin
      grad_pre = 32'd0;
    end else begin
      grad_pre = {sd_q[SdN-1].neg,
                  (q_grad[30:0] > MAX_MAG[30:0]) ? MAX_MAG[30:0] : q_grad[30:0]};
    end
  end

  mlg_fmul u_mul_loss (
    .clk_i  (clk_i),
    .en_i   (en),
    .a_i    (ratio),
    .b_i    (PERCENT),
    .prod_o (pct)
  );

  mlg_fmul u_mul_grad (
    .clk_i  (clk_i),
    .en_i   (en),
    .a_i    (grad_pre),
    .b_i    (loss_scale_q),
    .prod_o (grad_sc)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      zm_dq[0] <= sd_q[SdN-1].zm;
      for (int i = 1; i < MUL_LAT; i++) zm_dq[i] <= zm_dq[i-1];
    end
  end

  // A NaN or infinite percentage is caught by the exponent check and takes the cap.
  always_comb begin
    if (zm_dq[MUL_LAT-1]) begin
      loss32 = 32'd0;
    end else if ((pct[30:23] == 8'hFF) || (pct[30:0] >= MAX_MAG[30:0])) begin
      loss32 = MAX_MAG;
    end else begin
      loss32 = pct;
    end
    out_loss_d = loss_half_q ? {16'd0, to_half(loss32)} : loss32;
    out_grad_d = grad_half_q ? {16'd0, to_half(grad_sc)} : grad_sc;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_loss_q <= out_loss_d;
      out_grad_q <= out_grad_d;
      out_zm_q   <= zm_dq[MUL_LAT-1];
    end
  end

  assign out_o.valid      = v_q[Lat-1];
  assign out_o.loss_value = out_loss_q;
  assign out_o.grad_value = out_grad_q;

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while a result beat is stalled");

  a_match_zero_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_zm_q) |-> (out_o.loss_value == 32'd0))
    else $error("exact match did not give a zero loss");

endmodule

[tb/mape_loss_gradient_tb.sv]
// Self-checking testbench for the MAPE loss and gradient pipeline, with a bit-exact FP32 predictor.
module mape_loss_gradient_tb import mlg_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  REG_SPARE = 2'd3;
  localparam logic [31:0] F_QUIET   = 32'h0040_0000;
  localparam logic [31:0] F_DEFNAN  = 32'hFFC0_0000;
  localparam logic [31:0] F_ZERO    = 32'h0000_0000;
  localparam logic [31:0] F_EPS     = 32'h38D1_B717;
  localparam logic [31:0] F_HUNDRED = 32'h42C8_0000;
  localparam logic [31:0] F_THOUS   = 32'h447A_0000;
  localparam logic [31:0] F_ONE     = 32'h3F80_0000;
  localparam int          DRAIN     = 30;

  typedef struct packed {
    logic [31:0] loss;
    logic [31:0] grad;
  } mape_res_t;

  typedef struct packed {
    logic [31:0] pred;
    logic [31:0] lbl;
    logic        typed;
    logic [31:0] loss;
    logic [31:0] grad;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [31:0] cfg_wdata;

  mlg_in_if  in_ch ();
  mlg_out_if out_ch ();

  mape_loss_gradient dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  mape_res_t   pending_results[$];
  int          mismatches;
  logic        no_idle;
  logic        half_loss;
  logic        half_grad;
  logic [31:0] grad_scale;
  dir_row_t    dir_rows [0:19];

  // ---------------- FP32 arithmetic, round to nearest even ----------------

  function automatic logic f_nan(input logic [31:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
  endfunction

  function automatic logic f_inf(input logic [31:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
  endfunction

  function automatic logic f_zero(input logic [31:0] b);
    return b[30:0] == 31'd0;
  endfunction

  // Value is m * 2^e.
  function automatic void f_split(input logic [31:0] b, output int e, output logic [23:0] m);
    if (b[30:23] == 8'd0) begin
      m = {1'b0, b[22:0]};
      e = -149;
    end else begin
      m = {1'b1, b[22:0]};
      e = int'(b[30:23]) - 150;
    end
  endfunction

  // Rounds sign * (mag + sticky fraction) * 2^e to a single.
  function automatic logic [31:0] f_pack(input logic s, input int e, input logic [127:0] mag,
                                         input logic sticky);
    int           n;
    int           sh;
    logic [127:0] q;
    logic         g;
    logic         rest;
    if (mag == 128'd0) return {s, 31'd0};
    n = 0;
    for (int i = 0; i < 128; i++) if (mag[i]) n = i;
    sh = n - 23;
    if (sh < -149 - e) sh = -149 - e;
    if (sh <= 0) begin
      q    = mag << (-sh);
      g    = 1'b0;
      rest = 1'b0;
    end else if (sh > 127) begin
      q    = '0;
      g    = 1'b0;
      rest = 1'b1;
    end else begin
      q    = mag >> sh;
      g    = mag[sh-1];
      rest = sticky | ((mag & ((128'd1 << (sh - 1)) - 128'd1)) != 128'd0);
    end
    if (g && (rest || q[0])) q = q + 128'd1;
    if (q[24]) begin
      q  = q >> 1;
      sh = sh + 1;
    end
    if (q[23]) begin
      if (e + sh + 150 >= 255) return {s, 8'hFF, 23'd0};
      return {s, 8'(e + sh + 150), q[22:0]};
    end
    return {s, 8'd0, q[22:0]};
  endfunction

  function automatic logic [31:0] f_sub(input logic [31:0] a, input logic [31:0] b);
    logic [31:0]  bn;
    int           ea;
    int           eb;
    int           ec;
    logic [23:0]  ma;
    logic [23:0]  mb;
    logic [127:0] wa;
    logic [127:0] wb;
    if (f_nan(a)) return a | F_QUIET;
    if (f_nan(b)) return b | F_QUIET;
    bn = b ^ 32'h8000_0000;
    if (f_inf(a) && f_inf(bn)) return (a[31] == bn[31]) ? a : F_DEFNAN;
    if (f_inf(a)) return a;
    if (f_inf(bn)) return bn;
    if (f_zero(a) && f_zero(bn)) return {a[31] & bn[31], 31'd0};
    if (f_zero(a)) return bn;
    if (f_zero(bn)) return a;
    f_split(a, ea, ma);
    f_split(bn, eb, mb);
    // A far smaller operand only matters as a sticky contribution below the guard bit.
    if (ea > eb + 60) begin
      mb = 24'd1;
      eb = ea - 62;
    end else if (eb > ea + 60) begin
      ma = 24'd1;
      ea = eb - 62;
    end
    ec = (ea < eb) ? ea : eb;
    wa = 128'(ma) << (ea - ec);
    wb = 128'(mb) << (eb - ec);
    if (a[31] == bn[31]) return f_pack(a[31], ec, wa + wb, 1'b0);
    if (wa > wb) return f_pack(a[31], ec, wa - wb, 1'b0);
    if (wb > wa) return f_pack(bn[31], ec, wb - wa, 1'b0);
    return F_ZERO;
  endfunction

  function automatic logic [31:0] f_mul(input logic [31:0] a, input logic [31:0] b);
    logic        s;
    int          ea;
    int          eb;
    logic [23:0] ma;
    logic [23:0] mb;
    if (f_nan(a)) return a | F_QUIET;
    if (f_nan(b)) return b | F_QUIET;
    s = a[31] ^ b[31];
    if (f_inf(a) || f_inf(b)) begin
      if (f_zero(a) || f_zero(b)) return F_DEFNAN;
      return {s, 8'hFF, 23'd0};
    end
    if (f_zero(a) || f_zero(b)) return {s, 31'd0};
    f_split(a, ea, ma);
    f_split(b, eb, mb);
    return f_pack(s, ea + eb, 128'(ma) * 128'(mb), 1'b0);
  endfunction

  function automatic logic [31:0] f_div(input logic [31:0] a, input logic [31:0] b);
    logic         s;
    int           ea;
    int           eb;
    logic [23:0]  ma;
    logic [23:0]  mb;
    logic [127:0] num;
    if (f_nan(a)) return a | F_QUIET;
    if (f_nan(b)) return b | F_QUIET;
    s = a[31] ^ b[31];
    if (f_inf(a)) return f_inf(b) ? F_DEFNAN : {s, 8'hFF, 23'd0};
    if (f_inf(b)) return {s, 31'd0};
    if (f_zero(b)) return f_zero(a) ? F_DEFNAN : {s, 8'hFF, 23'd0};
    if (f_zero(a)) return {s, 31'd0};
    f_split(a, ea, ma);
    f_split(b, eb, mb);
    num = 128'(ma) << 80;
    return f_pack(s, ea - eb - 80, num / 128'(mb), (num % 128'(mb)) != 128'd0);
  endfunction

  function automatic logic [31:0] f_order(input logic [31:0] b);
    if (f_zero(b)) return 32'h8000_0000;
    return b[31] ? ~b : {1'b1, b[30:0]};
  endfunction

  function automatic logic f_lt(input logic [31:0] a, input logic [31:0] b);
    if (f_nan(a) || f_nan(b)) return 1'b0;
    return f_order(a) < f_order(b);
  endfunction

  function automatic logic [31:0] narrow_to_half(input logic [31:0] b);
    logic [31:0] sg;
    logic [31:0] man;
    logic [31:0] m;
    logic [31:0] h;
    logic [31:0] rem;
    int          e;
    int          sh;
    sg  = {16'd0, b[31], 15'd0};
    man = {9'd0, b[22:0]};
    if (b[30:23] == 8'hFF) return sg | ((man != 0) ? 32'h7E00 : 32'h7C00);
    e = int'(b[30:23]) - 112;
    if (e >= 31) return sg | 32'h7C00;
    if (e <= 0) begin
      if (b[30:23] == 8'd0 || e < -10) return sg;
      m   = man | 32'h0080_0000;
      sh  = 14 - e;
      h   = m >> sh;
      rem = m & ((32'd1 << sh) - 32'd1);
      if (rem > (32'd1 << (sh - 1)) || (rem == (32'd1 << (sh - 1)) && h[0])) h = h + 1;
      return sg | h;
    end
    h   = (32'(e) << 10) | (man >> 13);
    rem = man & 32'h1FFF;
    if (rem > 32'h1000 || (rem == 32'h1000 && h[0])) h = h + 1;
    return sg | h;
  endfunction

  // Expected loss and scaled gradient for one element pair under the current settings.
  function automatic mape_res_t mape_predict(input logic [31:0] p, input logic [31:0] l);
    mape_res_t   r;
    logic [31:0] le;
    logic [31:0] ediff;
    logic [31:0] pct;
    logic [31:0] num;
    logic        exact;
    exact = (p[30:23] != 8'hFF) && ((p == l) || (f_zero(p) && f_zero(l)));
    // Labels near zero are moved out to plus or minus the epsilon; NaN goes positive.
    if (f_lt(l, F_ZERO)) le = f_lt(F_EPS | 32'h8000_0000, l) ? (F_EPS | 32'h8000_0000) : l;
    else                 le = f_lt(F_EPS, l) ? l : F_EPS;
    ediff = f_sub(p, le);
    pct = f_mul(f_div(ediff, le) & 32'h7FFF_FFFF, F_HUNDRED);
    r.loss = f_lt(pct, F_THOUS) ? pct : F_THOUS;
    if (f_lt(F_ZERO, ediff))      num = F_HUNDRED;
    else if (f_lt(ediff, F_ZERO)) num = F_HUNDRED | 32'h8000_0000;
    else                          num = F_ZERO;
    r.grad = f_div(num, le & 32'h7FFF_FFFF);
    if (f_lt(r.grad, F_THOUS | 32'h8000_0000)) r.grad = F_THOUS | 32'h8000_0000;
    if (f_lt(F_THOUS, r.grad)) r.grad = F_THOUS;
    if (exact) begin
      r.loss = F_ZERO;
      r.grad = F_ZERO;
    end
    r.grad = f_mul(r.grad, grad_scale);
    if (half_loss) r.loss = narrow_to_half(r.loss);
    if (half_grad) r.grad = narrow_to_half(r.grad);
    return r;
  endfunction

  // ---------------- clock, reset, limit ----------------

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("[mape_loss_gradient] ERROR");
    $finish;
  end

  // ---------------- stimulus ----------------

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    case (idx)
      REG_LOSS_HALF:  half_loss  = data[0];
      REG_GRAD_HALF:  half_grad  = data[0];
      REG_LOSS_SCALE: grad_scale = data;
      default: ;
    endcase
  endtask

  task automatic send_pair(input logic [31:0] p, input logic [31:0] l, input logic typed,
                           input mape_res_t known);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.prediction <= p;
    in_ch.label      <= l;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    pending_results.push_back(typed ? known : mape_predict(p, l));
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(0, 9))
      3, 4, 5: v[30:23] = 8'($urandom_range(117, 137));
      6:       v[30:23] = 8'($urandom_range(100, 118));
      7: begin
        case ($urandom_range(0, 9))
          0: v = 32'h0000_0000;
          1: v = 32'h8000_0000;
          2: v = 32'h7F80_0000;
          3: v = 32'hFF80_0000;
          4: v = {v[31], 8'hFF, 1'b1, v[21:0]};
          5: v = {v[31], 8'hFF, 1'b0, v[21:1], 1'b1};
          6: v = {v[31], 31'h7F7F_FFFF};
          7: v = {v[31], 31'd1};
          8: v = {v[31], F_EPS[30:0]};
          default: v = {v[31], F_ONE[30:0]};
        endcase
      end
      8: v[30:23] = 8'd0;
      9: v[30:23] = 8'($urandom_range(200, 254));
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    logic [31:0] p;
    logic [31:0] l;
    logic [31:0] scales [0:8];
    logic [1:0]  halves [0:8];
    mape_res_t   none;

    dir_rows = '{
      '{32'h3F80_0000, 32'h3F80_0000, 1'b1, 32'h0000_0000, 32'h0000_0000},
      '{32'h0000_0000, 32'h8000_0000, 1'b1, 32'h0000_0000, 32'h0000_0000},
      '{32'h4000_0000, 32'h3F80_0000, 1'b1, 32'h42C8_0000, 32'h42C8_0000},
      '{32'h0000_0000, 32'h3F80_0000, 1'b1, 32'h42C8_0000, 32'hC2C8_0000},
      '{32'h7F7F_FFFF, 32'h3F80_0000, 1'b1, 32'h447A_0000, 32'h42C8_0000},
      '{32'h3F80_0000, 32'h0000_0000, 1'b1, 32'h447A_0000, 32'h447A_0000},
      '{32'hFF7F_FFFF, 32'h3F80_0000, 1'b0, 32'h0, 32'h0},
      '{32'h0000_0001, 32'h0000_0000, 1'b0, 32'h0, 32'h0},
      '{32'h3F80_0000, 32'h8000_0001, 1'b0, 32'h0, 32'h0},
      '{32'h3F80_0000, 32'hB8D1_B717, 1'b0, 32'h0, 32'h0},
      '{32'h0000_0000, 32'h38D1_B717, 1'b0, 32'h0, 32'h0},
      '{32'h7F80_0000, 32'h3F80_0000, 1'b0, 32'h0, 32'h0},
      '{32'hFF80_0000, 32'hBF80_0000, 1'b0, 32'h0, 32'h0},
      '{32'h7FC0_0000, 32'h3F80_0000, 1'b0, 32'h0, 32'h0},
      '{32'h3F80_0000, 32'h7FC0_0001, 1'b0, 32'h0, 32'h0},
      '{32'h3F80_0000, 32'h7F80_0000, 1'b0, 32'h0, 32'h0},
      '{32'hC2C8_0000, 32'hC2C8_0000, 1'b0, 32'h0, 32'h0},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0},
      '{32'h3F80_0001, 32'h3F80_0000, 1'b0, 32'h0, 32'h0},
      '{32'h8000_0000, 32'hB8D1_B716, 1'b0, 32'h0, 32'h0}
    };
    scales = '{32'h3F80_0000, 32'h3A80_0000, 32'h7F7F_FFFF, 32'h0000_0001, 32'h0000_0000,
               32'h7F80_0000, 32'hFFFF_FFFF, $urandom(), 32'hC300_0000};
    halves = '{2'b11, 2'b10, 2'b01, 2'b11, 2'b00, 2'b11, 2'b10, 2'b11, 2'b00};
    none = '0;

    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = REG_LOSS_HALF;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.prediction = '0;
    in_ch.label      = '0;
    mismatches       = 0;
    no_idle          = 1'b0;
    half_loss        = 1'b0;
    half_grad        = 1'b0;
    grad_scale       = F_ONE;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_pair(dir_rows[i].pred, dir_rows[i].lbl, dir_rows[i].typed,
                '{dir_rows[i].loss, dir_rows[i].grad});
    settle();

    for (int ph = 0; ph < 9; ph++) begin
      // A write to the unused index must leave every register alone.
      write_reg(REG_SPARE, $urandom());
      write_reg(REG_LOSS_HALF, {31'($urandom()), halves[ph][1]});
      write_reg(REG_GRAD_HALF, {31'($urandom()), halves[ph][0]});
      write_reg(REG_LOSS_SCALE, scales[ph]);
      cfg_we  <= 1'b0;
      no_idle = (ph == 2) || (ph == 5);
      for (int n = 0; n < 200; n++) begin
        l = pick_operand();
        case ($urandom_range(0, 19))
          0, 1, 2: p = l;
          3, 4:    p = l ^ 32'($urandom_range(1, 255));
          default: p = pick_operand();
        endcase
        send_pair(p, l, 1'b0, none);
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("[mape_loss_gradient] OK");
    end else begin
      $display("[mape_loss_gradient] ERROR");
    end
    $finish;
  end

  // ---------------- result side ----------------

  initial begin
    int        stall;
    mape_res_t want;
    out_ch.ready = 1'b1;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: loss %h grad %h",
                   out_ch.loss_value, out_ch.grad_value);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.loss_value !== want.loss || out_ch.grad_value !== want.grad) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: loss %h (expected %h) grad %h (expected %h)",
                     out_ch.loss_value, want.loss, out_ch.grad_value, want.grad);
        end
      end
    end
  end

endmodule
